>>> rtl/core/strided_tensor_sum_reduce_unit_assert.svh
// assertion macros for the strided tensor sum reduce unit
`ifndef STRIDED_TENSOR_SUM_REDUCE_UNIT_ASSERT_SVH
`define STRIDED_TENSOR_SUM_REDUCE_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk, off during rst
`define STSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define STSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/stsr_pkg.sv
// shared types and constants of the strided tensor sum reduce unit
package stsr_pkg;

  localparam int PACK_DIMS = 4;
  localparam int IDX_W     = 12;
  localparam int SIZE_W    = 13;
  localparam int STRIDE_W  = 12;
  localparam int OFF_W     = 12;
  localparam int SUM_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 52;

  localparam logic [SIZE_W-1:0] IDX_LIMIT = 13'd4096;

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_DIMS    = 3'd0,
    CFG_REDUCE_MASK = 3'd1,
    CFG_DIM_SIZES   = 3'd2,
    CFG_IN_STRIDES  = 3'd3,
    CFG_OUT_STRIDES = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASE,
    ST_RED,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic              req_type;
    logic [11:0]       elem_addr;
    logic signed [31:0] elem_value;
  } req_t;

  typedef struct packed {
    logic [OFF_W-1:0]        out_offset;
    logic signed [SUM_W-1:0] reduced_sum;
    logic                    last;
  } res_t;

endpackage

>>> rtl/core/stsr_store.sv
// element store: one write port, one read port with registered data
module stsr_store #(
  parameter int DEPTH      = 4096,
  parameter int DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_WIDTH-1:0]    wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_WIDTH-1:0]    rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/stsr_odometer.sv
// odometer step over a selected set of dimensions, highest dimension fastest
module stsr_odometer #(
  parameter int LD = 4
) (
  input  logic [stsr_pkg::IDX_W-1:0]  idx      [LD],
  input  logic [stsr_pkg::SIZE_W-1:0] size     [LD],
  input  logic [LD-1:0]               sel,
  output logic [stsr_pkg::IDX_W-1:0]  idx_next [LD],
  output logic [LD-1:0]               step,
  output logic [LD-1:0]               wrap,
  output logic                        done
);

  import stsr_pkg::*;

  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int d = LD - 1; d >= 0; d--) begin
      idx_next[d] = idx[d];
      step[d]     = 1'b0;
      wrap[d]     = 1'b0;
      if (sel[d] && carry) begin
        if ((SIZE_W'(idx[d]) + SIZE_W'(1)) >= size[d]) begin
          idx_next[d] = '0;
          wrap[d]     = 1'b1;
        end else begin
          idx_next[d] = idx[d] + 1'b1;
          step[d]     = 1'b1;
          carry       = 1'b0;
        end
      end
    end
    done = carry;
  end

endmodule

>>> rtl/core/strided_tensor_sum_reduce_unit.sv
// strided tensor sum reduce unit: top level
// Holds a tensor of DEPTH elements (DEPTH a power of two) and returns, one
// per compute command, the wrapping sum over the dimensions set in
// reduce_mask at the current index of the kept dimensions, walking the kept
// dimensions with the highest one fastest and restarting after the last.
// Command channel: a beat is taken when start is high and busy is low.
// A write beat (req_type 0) stores elem_value at elem_addr in that cycle,
// gives no result and leaves busy low.
// A compute beat raises busy. The kept-dimension base offsets go through one
// shared 12x12 multiplier, two products per dimension. The reduced span is
// then read one store word per cycle, at most DEPTH words, and a drain
// state adds the last read word to the sum.
// done is high for one cycle with result, both registered in the drain
// state; busy is low in that cycle, so the next beat can
// be taken then. The receiver cannot stall: result is valid only while done.
// Config channel: cfg_ready is always high; a beat writes register
// cfg_index, indexes beyond the list are dropped. Write it only while idle.
// rst clears the walk position and loads register defaults; the store is
// not cleared and must be written before it is read.
`include "strided_tensor_sum_reduce_unit_assert.svh"

module strided_tensor_sum_reduce_unit #(
  parameter int MAX_DIMS   = 4,
  parameter int DEPTH      = 4096,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  stsr_pkg::req_t                  req,
  output logic                            done,
  output stsr_pkg::res_t                  result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [stsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stsr_pkg::CFG_DATA_W-1:0] cfg_data
);

  import stsr_pkg::*;

  localparam int LD     = (MAX_DIMS < PACK_DIMS) ? MAX_DIMS : PACK_DIMS;
  localparam int AW     = $clog2(DEPTH);
  localparam int BSTEPS = 2 * LD;
  localparam int BCW    = $clog2(BSTEPS + 1);

  state_t state, state_next;

  logic [2:0]              num_dims;
  logic [3:0]              reduce_mask;
  logic [4*SIZE_W-1:0]     dim_sizes;
  logic [4*STRIDE_W-1:0]   in_strides;
  logic [4*STRIDE_W-1:0]   out_strides;

  logic [SIZE_W-1:0]       size [LD];
  logic [STRIDE_W-1:0]     istr [LD];
  logic [STRIDE_W-1:0]     ostr [LD];
  logic [2:0]              nd_eff;
  logic [LD-1:0]           red_set;
  logic [LD-1:0]           keep_set;

  logic [IDX_W-1:0]        keep_index [LD];
  logic [IDX_W-1:0]        keep_next  [LD];
  logic                    keep_done;
  logic [IDX_W-1:0]        ridx       [LD];
  logic [IDX_W-1:0]        ridx_next  [LD];
  logic [LD-1:0]           red_step;
  logic [LD-1:0]           red_wrap;
  logic                    red_done;
  logic [AW-1:0]           contrib    [LD];

  logic [BCW-1:0]          bcnt;
  logic [IDX_W-1:0]        m_idx;
  logic [STRIDE_W-1:0]     m_str;
  logic                    m_keep;
  logic                    m_out;
  logic [IDX_W+STRIDE_W-1:0] mul_full;
  logic [AW-1:0]           prod;
  logic                    prod_en;
  logic                    prod_out;
  logic [AW-1:0]           kbase;
  logic [AW-1:0]           obase;

  logic [AW-1:0]           rcount;
  logic                    rd_en;
  logic                    rd_v;
  logic [AW-1:0]           rd_addr;
  logic [DATA_WIDTH-1:0]   rd_data;
  logic [DATA_WIDTH-1:0]   acc;
  logic [DATA_WIDTH-1:0]   acc_sum;

  logic                    accept;
  logic                    wr_en;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign wr_en     = accept && (req.req_type == REQ_WRITE);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims    <= 3'd1;
      reduce_mask <= 4'd1;
      dim_sizes   <= 52'd549822930945;
      in_strides  <= '0;
      out_strides <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NUM_DIMS:    num_dims    <= cfg_data[2:0];
        CFG_REDUCE_MASK: reduce_mask <= cfg_data[3:0];
        CFG_DIM_SIZES:   dim_sizes   <= cfg_data[4*SIZE_W-1:0];
        CFG_IN_STRIDES:  in_strides  <= cfg_data[4*STRIDE_W-1:0];
        CFG_OUT_STRIDES: out_strides <= cfg_data[4*STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // decoded dimension view
  always_comb begin
    if (num_dims == 3'd0) begin
      nd_eff = 3'd1;
    end else if (num_dims > 3'(LD)) begin
      nd_eff = 3'(LD);
    end else begin
      nd_eff = num_dims;
    end
    for (int d = 0; d < LD; d++) begin
      size[d] = dim_sizes[SIZE_W*d +: SIZE_W];
      if (size[d] == '0) begin
        size[d] = SIZE_W'(1);
      end else if (size[d] > IDX_LIMIT) begin
        size[d] = IDX_LIMIT;
      end
      istr[d]     = in_strides[STRIDE_W*d +: STRIDE_W];
      ostr[d]     = out_strides[STRIDE_W*d +: STRIDE_W];
      red_set[d]  = (3'(d) < nd_eff) && reduce_mask[d];
      keep_set[d] = (3'(d) < nd_eff) && !reduce_mask[d];
    end
  end

  stsr_odometer #(.LD(LD)) u_red_odo (
    .idx      (ridx),
    .size     (size),
    .sel      (red_set),
    .idx_next (ridx_next),
    .step     (red_step),
    .wrap     (red_wrap),
    .done     (red_done)
  );

  stsr_odometer #(.LD(LD)) u_keep_odo (
    .idx      (keep_index),
    .size     (size),
    .sel      (keep_set),
    .idx_next (keep_next),
    .step     (),
    .wrap     (),
    .done     (keep_done)
  );

  // shared multiplier operand select: even step input stride, odd step output stride
  always_comb begin
    m_idx  = '0;
    m_str  = '0;
    m_keep = 1'b0;
    m_out  = 1'b0;
    for (int d = 0; d < LD; d++) begin
      if (bcnt == BCW'(2 * d)) begin
        m_idx  = keep_index[d];
        m_str  = istr[d];
        m_keep = keep_set[d];
        m_out  = 1'b0;
      end
      if (bcnt == BCW'(2 * d + 1)) begin
        m_idx  = keep_index[d];
        m_str  = ostr[d];
        m_keep = keep_set[d];
        m_out  = 1'b1;
      end
    end
    mul_full = m_idx * m_str;
  end

  always_comb begin
    rd_addr = kbase;
    for (int d = 0; d < LD; d++) begin
      rd_addr = rd_addr + contrib[d];
    end
  end

  assign acc_sum = acc + rd_data;

  stsr_store #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(req.elem_addr)),
    .wr_data (DATA_WIDTH'($unsigned(req.elem_value))),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    rd_en      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept && (req.req_type == REQ_COMPUTE)) begin
          state_next = ST_BASE;
        end
      end
      ST_BASE: begin
        if (bcnt == BCW'(BSTEPS)) begin
          state_next = ST_RED;
        end
      end
      ST_RED: begin
        rd_en = 1'b1;
        if (red_done || (rcount == AW'(DEPTH - 1))) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      bcnt    <= '0;
      prod_en <= 1'b0;
      rd_v    <= 1'b0;
      done    <= 1'b0;
      kbase   <= '0;
      obase   <= '0;
      for (int d = 0; d < LD; d++) begin
        keep_index[d] <= '0;
      end
    end else begin
      done <= 1'b0;
      rd_v <= rd_en;
      case (state)
        ST_IDLE: begin
          if (accept && (req.req_type == REQ_COMPUTE)) begin
            bcnt    <= '0;
            prod_en <= 1'b0;
            kbase   <= '0;
            obase   <= '0;
          end
        end
        ST_BASE: begin
          bcnt    <= bcnt + 1'b1;
          prod_en <= m_keep;
          if (prod_en) begin
            if (prod_out) begin
              obase <= obase + prod;
            end else begin
              kbase <= kbase + prod;
            end
          end
        end
        ST_DRAIN: begin
          keep_index <= keep_next;
          done       <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // walk and sum payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        rcount <= '0;
        acc    <= '0;
        for (int d = 0; d < LD; d++) begin
          ridx[d]    <= '0;
          contrib[d] <= '0;
        end
      end
      ST_BASE: begin
        prod     <= AW'(mul_full);
        prod_out <= m_out;
      end
      ST_RED: begin
        ridx   <= ridx_next;
        rcount <= rcount + 1'b1;
        for (int d = 0; d < LD; d++) begin
          if (red_wrap[d]) begin
            contrib[d] <= '0;
          end else if (red_step[d]) begin
            contrib[d] <= contrib[d] + AW'(istr[d]);
          end
        end
        if (rd_v) begin
          acc <= acc_sum;
        end
      end
      ST_DRAIN: begin
        result.out_offset  <= OFF_W'(obase);
        result.reduced_sum <= $signed(SUM_W'(acc_sum));
        result.last        <= keep_done;
      end
      default: ;
    endcase
  end

  `STSR_ASSERT_NEXT(a_drain_gives_done, state == ST_DRAIN, done, "drain not followed by done")
  `STSR_ASSERT_NOW(a_done_when_idle, done, !busy && $past(state) == ST_DRAIN, "done outside idle")
  `STSR_ASSERT_NOW(a_read_data_in_walk, rd_v, $past(state) == ST_RED, "read data without walk")

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench for the strided tensor sum reduce unit: directed and random commands checked beat by beat
module tb;
  import stsr_pkg::*;

  localparam int DEPTH    = 4096;
  localparam int SETTLE   = 16;
  localparam int WATCHDOG = 20000;

  class sum_scoreboard;
    logic [31:0] mem [DEPTH];
    bit mem_set [DEPTH];
    logic [2:0] nd_reg;
    logic [3:0] mask_reg;
    logic [51:0] size_reg;
    logic [47:0] istr_reg;
    logic [47:0] ostr_reg;
    int keep_pos [PACK_DIMS];
    int sz [PACK_DIMS];
    int istr [PACK_DIMS];
    int ostr [PACK_DIMS];
    int keep_dims [$];
    int red_dims [$];
    int span_addr [$];
    res_t sums_due [$];
    int errors;

    function new();
      nd_reg = 3'd1;
      mask_reg = 4'd1;
      size_reg = {4{13'd1}};
      istr_reg = '0;
      ostr_reg = '0;
      foreach (keep_pos[d]) keep_pos[d] = 0;
      errors = 0;
    endfunction

    function int pending();
      return sums_due.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_NUM_DIMS: nd_reg = data[2:0];
        CFG_REDUCE_MASK: mask_reg = data[3:0];
        CFG_DIM_SIZES: size_reg = data[51:0];
        CFG_IN_STRIDES: istr_reg = data[47:0];
        CFG_OUT_STRIDES: ostr_reg = data[47:0];
        default: ;
      endcase
    endfunction

    function void decode();
      int nd;
      int s;
      nd = int'(nd_reg);
      if (nd == 0) nd = 1;
      if (nd > PACK_DIMS) nd = PACK_DIMS;
      keep_dims.delete();
      red_dims.delete();
      for (int d = 0; d < PACK_DIMS; d++) begin
        s = int'(size_reg[SIZE_W*d +: SIZE_W]);
        if (s == 0) s = 1;
        if (s > DEPTH) s = DEPTH;
        sz[d] = s;
        istr[d] = int'(istr_reg[STRIDE_W*d +: STRIDE_W]);
        ostr[d] = int'(ostr_reg[STRIDE_W*d +: STRIDE_W]);
        if (d < nd) begin
          if (mask_reg[d]) red_dims.insert(red_dims.size(), d);
          else keep_dims.insert(keep_dims.size(), d);
        end
      end
    endfunction

    // odometer step, last listed dim fastest; 1 when everything wrapped
    function bit roll(input int dims[$], ref int idx[PACK_DIMS]);
      int d;
      for (int j = dims.size() - 1; j >= 0; j--) begin
        d = dims[j];
        idx[d]++;
        if (idx[d] < sz[d]) return 1'b0;
        idx[d] = 0;
      end
      return 1'b1;
    endfunction

    // store addresses read by the next output, in walk order
    function void walk_span();
      int base;
      int roff;
      int ridx [PACK_DIMS];
      bit fin;
      decode();
      base = 0;
      foreach (keep_dims[i]) base += keep_pos[keep_dims[i]] * istr[keep_dims[i]];
      base = base % DEPTH;
      foreach (ridx[d]) ridx[d] = 0;
      span_addr.delete();
      do begin
        roff = 0;
        foreach (red_dims[i]) roff += ridx[red_dims[i]] * istr[red_dims[i]];
        span_addr.insert(span_addr.size(), (base + roff) % DEPTH);
        fin = roll(red_dims, ridx);
      end while (!fin && span_addr.size() < DEPTH);
    endfunction

    function void note_cmd(req_t r);
      int ooff;
      logic [31:0] total;
      res_t e;
      if (r.req_type == REQ_WRITE) begin
        mem[r.elem_addr] = r.elem_value;
        mem_set[r.elem_addr] = 1'b1;
        return;
      end
      walk_span();
      total = '0;
      foreach (span_addr[i]) total += mem[span_addr[i]];
      ooff = 0;
      foreach (keep_dims[i]) ooff += keep_pos[keep_dims[i]] * ostr[keep_dims[i]];
      e.out_offset = 12'(ooff % DEPTH);
      e.reduced_sum = total;
      e.last = roll(keep_dims, keep_pos);
      sums_due.push_back(e);
    endfunction

    function void check_sum(res_t got);
      res_t e;
      if (sums_due.size() == 0) begin
        $error("result with none expected: out_offset %0d reduced_sum %0d",
               got.out_offset, $signed(got.reduced_sum));
        errors++;
        return;
      end
      e = sums_due.pop_front();
      if (got.out_offset !== e.out_offset) begin
        $error("out_offset: expected %0d, got %0d", e.out_offset, got.out_offset);
        errors++;
      end
      if (got.reduced_sum !== e.reduced_sum) begin
        $error("reduced_sum: expected %0d, got %0d",
               $signed(e.reduced_sum), $signed(got.reduced_sum));
        errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  logic cfg_valid;
  logic cfg_ready;
  req_t req;
  res_t result;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  sum_scoreboard sb = new();
  int idle_pct;
  int quiet_cycles;

  strided_tensor_sum_reduce_unit i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_sum(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // start stays high across back-to-back beats
  task automatic send_item(input req_t r);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    sb.note_cmd(r);
  endtask

  task automatic drain();
    if (sb.pending() > 0) begin
      start <= 1'b0;
      do @(posedge clk); while (sb.pending() > 0);
    end
  endtask

  task automatic run_write(input logic [11:0] addr, input logic [31:0] value);
    req_t r;
    r.req_type = REQ_WRITE;
    r.elem_addr = addr;
    r.elem_value = value;
    send_item(r);
  endtask

  // fill any unwritten word of the span first, then ask for the output
  task automatic run_compute();
    req_t r;
    sb.walk_span();
    foreach (sb.span_addr[i]) begin
      if (!sb.mem_set[sb.span_addr[i]]) run_write(12'(sb.span_addr[i]), pick_value());
    end
    r.req_type = REQ_COMPUTE;
    r.elem_addr = 12'($urandom_range(0, DEPTH - 1));
    r.elem_value = $urandom;
    send_item(r);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic [2:0] nd, input logic [3:0] mask,
                           input logic [51:0] sizes, input logic [47:0] istr,
                           input logic [47:0] ostr);
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_beat(CFG_NUM_DIMS, 52'(nd));
    cfg_beat(CFG_REDUCE_MASK, 52'(mask));
    cfg_beat(CFG_DIM_SIZES, sizes);
    cfg_beat(CFG_IN_STRIDES, 52'(istr));
    cfg_beat(CFG_OUT_STRIDES, 52'(ostr));
    // unmapped index, must be dropped
    cfg_beat(3'($urandom_range(5, 7)), 52'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: drain();
        1, 2, 3, 4, 5: run_compute();
        default: begin
          if (sb.span_addr.size() > 0 && $urandom_range(0, 1))
            run_write(12'(sb.span_addr[$urandom_range(0, sb.span_addr.size() - 1)]),
                      pick_value());
          else
            run_write(12'($urandom_range(0, DEPTH - 1)), pick_value());
        end
      endcase
    end
  endtask

  initial begin
    logic [51:0] sizes;
    logic [47:0] istr;
    logic [47:0] ostr;
    int pcts [3];
    pcts = '{0, 62, 26};
    idle_pct = 0;
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults: one total of word 0
    run_write(12'd0, 32'h7fff_ffff);
    run_compute();
    drain();
    run_write(12'd0, 32'h8000_0000);
    run_compute();
    run_write(12'hfff, 32'hffff_ffff);

    // zero dim count, nothing reduced, keep walk of three with max out stride
    configure(3'd0, 4'h0, 52'd3, 48'd1, 48'hfff);
    repeat (4) run_compute();

    // dim count above range, everything reduced
    configure(3'd7, 4'hf, {4{13'd2}}, {12'd1, 12'd2, 12'd4, 12'd8}, {4{12'hfff}});
    repeat (2) run_compute();

    // oversized reduced span, zero strides: sum stops after a full store of reads
    configure(3'd4, 4'hf, {4{13'h1fff}}, 48'h0, {4{12'hfff}});
    run_compute();

    // all kept at max size and stride
    configure(3'd4, 4'h0, {4{13'h1fff}}, {4{12'hfff}}, {4{12'hfff}});
    repeat (3) run_compute();

    // zero sizes, stale keep index wraps
    configure(3'd4, 4'b0101, 52'h0, {12'd7, 12'd300, 12'd5, 12'd2049},
              {12'd1, 12'd2, 12'd3, 12'd4});
    repeat (2) run_compute();

    // mask bits above the dim count ignored
    configure(3'd2, 4'b1110, {13'd0, 13'd0, 13'd3, 13'd2}, {24'd0, 12'd17, 12'd1000},
              {24'd0, 12'd9, 12'd123});
    repeat (2) run_compute();

    for (int p = 0; p < 8; p++) begin
      idle_pct = pcts[p % 3];
      for (int d = 0; d < PACK_DIMS; d++) begin
        sizes[SIZE_W*d +: SIZE_W] = 13'($urandom_range(0, 4));
        istr[STRIDE_W*d +: STRIDE_W] = $urandom_range(0, 1) ? 12'($urandom_range(0, 4095))
                                                             : 12'($urandom_range(0, 3));
        ostr[STRIDE_W*d +: STRIDE_W] = 12'($urandom_range(0, 4095));
      end
      configure(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), sizes, istr, ostr);
      random_phase(8);
    end

    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/stsr_pkg.sv
rtl/core/stsr_store.sv
rtl/core/stsr_odometer.sv
rtl/core/strided_tensor_sum_reduce_unit.sv
tb/sv/tb.sv
